@@ rtl/alc_pkg.sv @@
package alc_pkg;

  localparam int MAX_LINES = 64;
  localparam int IDX_W     = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CNT_W     = $clog2(MAX_LINES + 1);
  localparam int CFG_W     = 7;
  localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int DRUM_W    = 4;
  localparam int BLK_W     = 8;
  localparam int HANDLE_W  = 32;
  localparam int STAMP_W   = 32;
  localparam int SLOT_W    = 6;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                command;
    logic [DRUM_W-1:0]   drum_id;
    logic [BLK_W-1:0]    block_no;
    logic [HANDLE_W-1:0] line_handle;
  } req_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] found_handle;
    logic [SLOT_W-1:0]   slot;
  } rsp_t;

  typedef struct packed {
    logic [DRUM_W-1:0]   drum;
    logic [BLK_W-1:0]    blk;
    logic [HANDLE_W-1:0] handle;
    logic [STAMP_W-1:0]  stamp;
  } entry_t;

endpackage

@@ rtl/alc_if.sv @@
interface alc_req_if;
  import alc_pkg::*;

  logic                valid;
  logic                ready;
  cmd_t                command;
  logic [DRUM_W-1:0]   drum_id;
  logic [BLK_W-1:0]    block_no;
  logic [HANDLE_W-1:0] line_handle;

  modport source (output valid, command, drum_id, block_no, line_handle, input ready);
  modport sink (input valid, command, drum_id, block_no, line_handle, output ready);
endinterface

interface alc_rsp_if;
  import alc_pkg::*;

  logic                valid;
  logic                ready;
  logic                hit;
  logic [HANDLE_W-1:0] found_handle;
  logic [SLOT_W-1:0]   slot;

  modport source (output valid, hit, found_handle, slot, input ready);
  modport sink (input valid, hit, found_handle, slot, output ready);
endinterface

interface alc_cfg_if;
  import alc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] lines_in_use;

  modport source (output valid, lines_in_use, input ready);
  modport sink (input valid, lines_in_use, output ready);
endinterface

@@ rtl/assoc_lru_block_cache.sv @@
// lookup and insert scan the n lines in use, n = lines in use, capped at 64: one tag memory read
// per entry, the memory read, the last check, write back and the result register
// a lookup miss skips the write back; flush, no-op and requests with no lines in use go to the result
// throughput: one request at a time, the next can be taken in the same cycle as the result is presented;
// a result held by a stalled receiver holds the next one back
// reset: valid bits cleared, access clock zero, lines_in_use 64; memory contents kept
module assoc_lru_block_cache (
  input logic       clk,
  input logic       rst_n,
  alc_req_if.sink   in_ch,
  alc_rsp_if.source out_ch,
  alc_cfg_if.sink   cfg_ch
);
  import alc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  req_t                 req_r, req_nxt;
  rsp_t                 res_r, res_nxt;
  rsp_t                 out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CFG_W-1:0]     lines_r;
  logic [STAMP_W-1:0]   clock_r, clock_nxt;
  logic [MAX_LINES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic [STAMP_W-1:0]   best_age_r, best_age_nxt;
  logic [IDX_W-1:0]     victim_r, victim_nxt;

  entry_t               mem [MAX_LINES];
  entry_t               rdata_r;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  entry_t               wr_data;

  logic [CMP_W-1:0]     lines_ext;
  logic [CNT_W-1:0]     n;
  logic                 in_acc;
  logic [STAMP_W-1:0]   age;
  logic                 tag_match;

  assign lines_ext = CMP_W'(lines_r);
  assign n         = (lines_ext > CMP_W'(MAX_LINES)) ? CNT_W'(MAX_LINES) : CNT_W'(lines_ext);
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign age       = clock_r - rdata_r.stamp;
  assign tag_match = valid_r[chk_idx_r] && (rdata_r.drum == req_r.drum_id) &&
                     (rdata_r.blk == req_r.block_no);

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit          = out_r.hit;
  assign out_ch.found_handle = out_r.found_handle;
  assign out_ch.slot         = out_r.slot;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    clock_nxt     = clock_r;
    valid_nxt     = valid_r;
    scan_idx_nxt  = scan_idx_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    best_age_nxt  = best_age_r;
    victim_nxt    = victim_r;
    rd_en         = 1'b0;
    rd_addr       = scan_idx_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = victim_r;
    wr_data       = '{drum: req_r.drum_id, blk: req_r.block_no,
                      handle: req_r.line_handle, stamp: clock_r};

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          req_nxt = '{command: in_ch.command, drum_id: in_ch.drum_id,
                      block_no: in_ch.block_no, line_handle: in_ch.line_handle};
          res_nxt      = '0;
          scan_idx_nxt = '0;
          victim_nxt   = '0;
          best_age_nxt = '0;
          priority if (in_ch.command == CMD_FLUSH) begin
            valid_nxt = '0;
            state_nxt = ST_RESP;
          end else if (in_ch.command == CMD_NOP) begin
            state_nxt = ST_RESP;
          end else begin
            clock_nxt = clock_r + 1'b1;
            state_nxt = (n == '0) ? ST_RESP : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // issue the next read
        if (scan_idx_r < n) begin
          rd_en        = 1'b1;
          scan_idx_nxt = scan_idx_r + 1'b1;
          chk_vld_nxt  = 1'b1;
          chk_idx_nxt  = scan_idx_r[IDX_W-1:0];
        end
        // check the entry read last cycle
        if (chk_vld_r) begin
          if (req_r.command == CMD_LOOKUP) begin
            if (tag_match) begin
              res_nxt.hit          = 1'b1;
              res_nxt.found_handle = rdata_r.handle;
              res_nxt.slot         = SLOT_W'(chk_idx_r);
              victim_nxt           = chk_idx_r;
              state_nxt            = ST_WRITE;
            end
          end else begin
            priority if (!valid_r[chk_idx_r]) begin
              res_nxt.hit  = 1'b1;
              res_nxt.slot = SLOT_W'(chk_idx_r);
              victim_nxt   = chk_idx_r;
              state_nxt    = ST_WRITE;
            end else if ((chk_idx_r == '0) || (age > best_age_r)) begin
              best_age_nxt = age;
              victim_nxt   = chk_idx_r;
            end
          end
        end else if (scan_idx_r >= n) begin
          if (req_r.command == CMD_LOOKUP) begin
            state_nxt = ST_RESP;
          end else begin
            res_nxt.hit  = 1'b1;
            res_nxt.slot = SLOT_W'(victim_r);
            state_nxt    = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        wr_en = 1'b1;
        if (req_r.command == CMD_LOOKUP) begin
          wr_data.handle = res_r.found_handle;
        end else begin
          valid_nxt[victim_r] = 1'b1;
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      lines_r     <= CFG_W'(64);
      clock_r     <= '0;
      valid_r     <= '0;
      chk_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clock_r     <= clock_nxt;
      valid_r     <= valid_nxt;
      chk_vld_r   <= chk_vld_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        lines_r <= cfg_ch.lines_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
    scan_idx_r <= scan_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    best_age_r <= best_age_nxt;
    victim_r   <= victim_nxt;
  end

  // tag and stamp memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (CNT_W'(wr_addr) < n))
    else $error("write beyond the lines in use");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.command == CMD_FLUSH)) |=> (valid_r == '0))
    else $error("flush left valid entries");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESP))
    else $error("result raised outside the response state");

endmodule

@@ sim/lru_cache_check.sv @@
`timescale 1ns / 100ps

module lru_cache_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           req_valid,
  input  logic                           req_ready,
  input  alc_pkg::cmd_t                  req_command,
  input  logic [alc_pkg::DRUM_W-1:0]     req_drum,
  input  logic [alc_pkg::BLK_W-1:0]      req_block,
  input  logic [alc_pkg::HANDLE_W-1:0]   req_handle,
  input  logic                           rsp_valid,
  input  logic                           rsp_ready,
  input  logic                           rsp_hit,
  input  logic [alc_pkg::HANDLE_W-1:0]   rsp_handle,
  input  logic [alc_pkg::SLOT_W-1:0]     rsp_slot,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [alc_pkg::CFG_W-1:0]      cfg_lines,
  output int                             fail_count,
  output int                             pending,
  output int                             hit_count,
  output int                             evict_count
);
  import alc_pkg::*;

  logic               line_valid [MAX_LINES];
  entry_t             line_store [MAX_LINES];
  logic [STAMP_W-1:0] use_clock;
  logic [CFG_W-1:0]   lines_cfg;
  rsp_t               expected_q [$];
  int                 mismatches;
  int                 hit_tally;
  int                 evict_tally;

  assign fail_count  = mismatches;
  assign hit_count   = hit_tally;
  assign evict_count = evict_tally;

  function automatic rsp_t cache_access(input cmd_t cmd, input logic [DRUM_W-1:0] drum,
                                        input logic [BLK_W-1:0] blk,
                                        input logic [HANDLE_W-1:0] handle);
    rsp_t               res;
    int                 n;
    int                 idx;
    int                 chosen;
    logic [STAMP_W-1:0] age;
    logic [STAMP_W-1:0] oldest;
    res = '0;
    n = (int'(lines_cfg) > MAX_LINES) ? MAX_LINES : int'(lines_cfg);
    chosen = -1;
    case (cmd)
      CMD_FLUSH: begin
        for (idx = 0; idx < MAX_LINES; idx++) line_valid[idx] = 1'b0;
      end
      CMD_LOOKUP: begin
        use_clock = use_clock + 1'b1;
        for (idx = 0; idx < n && chosen < 0; idx++)
          if (line_valid[idx] && line_store[idx].drum == drum && line_store[idx].blk == blk)
            chosen = idx;
        if (chosen >= 0) begin
          line_store[chosen].stamp = use_clock;
          res.hit          = 1'b1;
          res.found_handle = line_store[chosen].handle;
          res.slot         = chosen[SLOT_W-1:0];
          hit_tally++;
        end
      end
      CMD_INSERT: begin
        use_clock = use_clock + 1'b1;
        if (n > 0) begin
          for (idx = 0; idx < n && chosen < 0; idx++)
            if (!line_valid[idx]) chosen = idx;
          // all lines full: oldest by wrapped age, lowest index on ties
          if (chosen < 0) begin
            chosen = 0;
            oldest = use_clock - line_store[0].stamp;
            for (idx = 1; idx < n; idx++) begin
              age = use_clock - line_store[idx].stamp;
              if (age > oldest) begin
                oldest = age;
                chosen = idx;
              end
            end
            evict_tally++;
          end
          line_valid[chosen]        = 1'b1;
          line_store[chosen].drum   = drum;
          line_store[chosen].blk    = blk;
          line_store[chosen].handle = handle;
          line_store[chosen].stamp  = use_clock;
          res.hit  = 1'b1;
          res.slot = chosen[SLOT_W-1:0];
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t got;
    rsp_t want;
    int   idx;
    if (!rst_n) begin
      for (idx = 0; idx < MAX_LINES; idx++) begin
        line_valid[idx] = 1'b0;
        line_store[idx] = '0;
      end
      use_clock   = '0;
      lines_cfg   = CFG_W'(MAX_LINES);
      mismatches  = 0;
      hit_tally   = 0;
      evict_tally = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) lines_cfg = cfg_lines;
      if (req_valid && req_ready)
        expected_q.push_back(cache_access(req_command, req_drum, req_block, req_handle));
      if (rsp_valid && rsp_ready) begin
        got.hit          = rsp_hit;
        got.found_handle = rsp_handle;
        got.slot         = rsp_slot;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: hit %0d handle %h slot %0d",
                     got.hit, got.found_handle, got.slot);
        end else begin
          want = expected_q.pop_front();
          if (got.hit !== want.hit || got.found_handle !== want.found_handle ||
              got.slot !== want.slot) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected hit %0d handle %h slot %0d,",
                        " got hit %0d handle %h slot %0d"},
                       want.hit, want.found_handle, want.slot,
                       got.hit, got.found_handle, got.slot);
          end
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

@@ sim/assoc_lru_block_cache_test.sv @@
`timescale 1ns / 100ps

module assoc_lru_block_cache_test;
  import alc_pkg::*;

  localparam int QUIET_LIMIT  = 5000;
  localparam int PHASE_ITEMS  = 210;
  localparam int PHASES       = 8;
  localparam int DRAIN_CYCLES = 80;

  logic clk;
  logic rst_n;
  int   send_idle;
  int   rsp_stall;
  int   quiet_cycles;
  int   sent;
  int   fail_count;
  int   pending;
  int   hit_count;
  int   evict_count;

  alc_req_if in_ch ();
  alc_rsp_if out_ch ();
  alc_cfg_if cfg_ch ();

  assoc_lru_block_cache dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lru_cache_check lru_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_ch.valid),
    .req_ready   (in_ch.ready),
    .req_command (in_ch.command),
    .req_drum    (in_ch.drum_id),
    .req_block   (in_ch.block_no),
    .req_handle  (in_ch.line_handle),
    .rsp_valid   (out_ch.valid),
    .rsp_ready   (out_ch.ready),
    .rsp_hit     (out_ch.hit),
    .rsp_handle  (out_ch.found_handle),
    .rsp_slot    (out_ch.slot),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_lines   (cfg_ch.lines_in_use),
    .fail_count  (fail_count),
    .pending     (pending),
    .hit_count   (hit_count),
    .evict_count (evict_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) out_ch.ready <= ($urandom_range(0, 99) >= rsp_stall);

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_req(input cmd_t cmd, input logic [DRUM_W-1:0] drum,
                          input logic [BLK_W-1:0] blk, input logic [HANDLE_W-1:0] handle);
    if ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.drum_id     <= drum;
    in_ch.block_no    <= blk;
    in_ch.line_handle <= handle;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_lines(input logic [CFG_W-1:0] lines);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.lines_in_use <= lines;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0]  phase_lines [PHASES];
    int                pick;
    int                hold_at;
    cmd_t              cmd;
    logic [DRUM_W-1:0] drum;
    logic [BLK_W-1:0]  blk;

    phase_lines = '{7'd64, 7'd4, 7'd127, 7'd8, 7'd0, 7'd65, 7'd1, 7'd16};
    send_idle    = 0;
    rsp_stall    = 0;
    sent         = 0;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CMD_NOP;
    in_ch.drum_id       <= '0;
    in_ch.block_no      <= '0;
    in_ch.line_handle   <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.lines_in_use <= CFG_W'(MAX_LINES);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty cache, tag extremes, duplicate insert, no-op and flush
    send_req(CMD_LOOKUP, 4'hF, 8'hFF, 32'h0000_0000);
    send_req(CMD_INSERT, 4'h0, 8'h00, 32'h0000_0000);
    send_req(CMD_INSERT, 4'hF, 8'hFF, 32'hFFFF_FFFF);
    send_req(CMD_LOOKUP, 4'h0, 8'h00, 32'hFFFF_FFFF);
    send_req(CMD_LOOKUP, 4'hF, 8'hFF, 32'h0000_0000);
    send_req(CMD_LOOKUP, 4'hF, 8'h00, 32'h0000_0000);
    send_req(CMD_INSERT, 4'h0, 8'h00, 32'h1234_5678);
    send_req(CMD_LOOKUP, 4'h0, 8'h00, 32'h0000_0000);
    send_req(CMD_NOP,    4'hF, 8'hFF, 32'hFFFF_FFFF);
    send_req(CMD_FLUSH,  4'h5, 8'hAA, 32'hA5A5_A5A5);
    send_req(CMD_LOOKUP, 4'hF, 8'hFF, 32'h0000_0000);

    // two lines: refreshed line survives, older one is replaced
    write_lines(7'd2);
    send_req(CMD_INSERT, 4'h1, 8'h01, 32'h0000_0011);
    send_req(CMD_INSERT, 4'h2, 8'h02, 32'h0000_0022);
    send_req(CMD_LOOKUP, 4'h1, 8'h01, 32'h0000_0000);
    send_req(CMD_INSERT, 4'h3, 8'h03, 32'h0000_0033);
    send_req(CMD_LOOKUP, 4'h2, 8'h02, 32'h0000_0000);
    send_req(CMD_LOOKUP, 4'h3, 8'h03, 32'h0000_0000);

    // no lines at all, then a count above the depth
    write_lines(7'd0);
    send_req(CMD_LOOKUP, 4'h3, 8'h03, 32'h0000_0000);
    send_req(CMD_INSERT, 4'h4, 8'h04, 32'hDEAD_BEEF);
    write_lines(7'd127);
    send_req(CMD_LOOKUP, 4'h3, 8'h03, 32'h0000_0000);
    send_req(CMD_LOOKUP, 4'h0, 8'h00, 32'h0000_0000);
    send_req(CMD_INSERT, 4'h9, 8'h55, 32'h5555_AAAA);

    for (int phase = 0; phase < PHASES; phase++) begin
      write_lines(phase_lines[phase]);
      case (phase % 4)
        0: begin send_idle = 0;  rsp_stall = 0;  end
        1: begin send_idle = 88; rsp_stall = 0;  end
        2: begin send_idle = 0;  rsp_stall = 88; end
        default: begin send_idle = 26; rsp_stall = 26; end
      endcase
      hold_at = $urandom_range(0, PHASE_ITEMS - 1);
      for (int item = 0; item < PHASE_ITEMS; item++) begin
        if (item == hold_at) drain_results();
        pick = $urandom_range(0, 199);
        if (pick < 100)      cmd = CMD_LOOKUP;
        else if (pick < 190) cmd = CMD_INSERT;
        else if (pick < 199) cmd = CMD_NOP;
        else                 cmd = CMD_FLUSH;
        // mostly a small tag pool so that hits and replacements happen
        if ($urandom_range(0, 99) < 85) begin
          drum = DRUM_W'($urandom_range(0, 3));
          blk  = BLK_W'($urandom_range(0, 7));
        end else begin
          drum = DRUM_W'($urandom());
          blk  = BLK_W'($urandom());
        end
        send_req(cmd, drum, blk, HANDLE_W'($urandom()));
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d requests over %0d line-count settings and four idling patterns",
             sent, PHASES + 3);
    $display("%0d lookup hits and %0d replacements of the oldest line", hit_count, evict_count);
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/alc_pkg.sv
rtl/alc_if.sv
rtl/assoc_lru_block_cache.sv
sim/lru_cache_check.sv
sim/assoc_lru_block_cache_test.sv
